// ===== rtl/hvt_pkg.sv =====
// Shared types, constants and helpers of the header value tokenizer.
package hvt_pkg;

  localparam int unsigned POS_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned END_POS_W    = 16;
  localparam int unsigned MAX_RES      = 3;
  localparam int unsigned TDATA_OUT_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DELIM_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELIM_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPACES  = 3'd7;

  localparam logic       KIND_TEXT = 1'b0;
  localparam logic       KIND_END  = 1'b1;

  localparam logic [1:0] REASON_DELIM     = 2'd0;
  localparam logic [1:0] REASON_END       = 2'd1;
  localparam logic [1:0] REASON_END_QUOTE = 2'd2;

  localparam logic [7:0]  SPACE_CHAR     = 8'h20;
  localparam logic [7:0]  QUOTE_RESET    = 8'd34;
  localparam logic [7:0]  ESCAPE_RESET   = 8'd92;
  localparam logic [31:0] SPACES_RESET   = 32'd168626464;

  typedef struct packed {
    logic [255:0] delim_map;
    logic         value_mode;
    logic [7:0]   quote_char;
    logic [7:0]   escape_char;
    logic [31:0]  space_chars;
  } cfg_t;

  typedef struct packed {
    logic pending_space;
    logic text_emitted;
    logic inside_quote;
    logic escape_pending;
  } tok_state_t;

  typedef struct packed {
    logic                 kind;
    logic [7:0]           ch;
    logic [1:0]           reason;
    logic [END_POS_W-1:0] pos;
    logic                 last;
  } result_t;

  function automatic result_t mk_text(input logic [7:0] ch);
    result_t r;
    r        = '0;
    r.kind   = KIND_TEXT;
    r.ch     = ch;
    return r;
  endfunction

  function automatic result_t mk_end(input logic [1:0] reason,
                                     input logic [END_POS_W-1:0] pos);
    result_t r;
    r        = '0;
    r.kind   = KIND_END;
    r.reason = reason;
    r.pos    = pos;
    return r;
  endfunction

endpackage

// ===== rtl/hvt_cfg.sv =====
// Configuration register file of the header value tokenizer.
module hvt_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hvt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hvt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output hvt_pkg::cfg_t                      cfg_o
);
  import hvt_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DELIM_0: cfg_d.delim_map[63:0]    = cfg_data_i;
        REG_DELIM_1: cfg_d.delim_map[127:64]  = cfg_data_i;
        REG_DELIM_2: cfg_d.delim_map[191:128] = cfg_data_i;
        REG_DELIM_3: cfg_d.delim_map[255:192] = cfg_data_i;
        REG_VALUE:   cfg_d.value_mode         = cfg_data_i[0];
        REG_QUOTE:   cfg_d.quote_char         = cfg_data_i[7:0];
        REG_ESCAPE:  cfg_d.escape_char        = cfg_data_i[7:0];
        REG_SPACES:  cfg_d.space_chars        = cfg_data_i[31:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim_map   <= '0;
      cfg_q.value_mode  <= 1'b1;
      cfg_q.quote_char  <= QUOTE_RESET;
      cfg_q.escape_char <= ESCAPE_RESET;
      cfg_q.space_chars <= SPACES_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/hvt_classify.sv =====
// Per-byte classification: results of one byte and the next token state.
module hvt_classify #(
  parameter int unsigned POS_BITS = hvt_pkg::POS_BITS_DEF
) (
  input  hvt_pkg::cfg_t       cfg_i,
  input  hvt_pkg::tok_state_t st_i,
  input  logic [POS_BITS-1:0] pos_i,
  input  logic [7:0]          ch_i,
  input  logic                last_i,
  output hvt_pkg::result_t    res_o [hvt_pkg::MAX_RES],
  output logic [1:0]          cnt_o,
  output hvt_pkg::tok_state_t st_o,
  output logic [POS_BITS-1:0] pos_o
);
  import hvt_pkg::*;

  localparam logic [POS_BITS-1:0] PosMax = '1;
  localparam logic [31:0]         EndPosMax = 32'((64'd1 << END_POS_W) - 64'd1);

  logic [POS_BITS-1:0]  pos_inc;
  logic [31:0]          pos_wide;
  logic [31:0]          inc_wide;
  logic [END_POS_W-1:0] pos_sat;
  logic [END_POS_W-1:0] inc_sat;
  logic [7:0]           sp0, sp1, sp2, sp3;
  logic                 is_delim, is_space;

  assign sp0      = cfg_i.space_chars[7:0];
  assign sp1      = cfg_i.space_chars[15:8];
  assign sp2      = cfg_i.space_chars[23:16];
  assign sp3      = cfg_i.space_chars[31:24];
  assign is_delim = cfg_i.delim_map[ch_i];
  assign is_space = (ch_i == sp0) || (ch_i == sp1) || (ch_i == sp2) || (ch_i == sp3);

  assign pos_inc  = (pos_i == PosMax) ? pos_i : pos_i + 1'b1;
  assign pos_wide = 32'(pos_i);
  assign inc_wide = 32'(pos_inc);
  assign pos_sat  = (pos_wide > EndPosMax) ? '1 : pos_wide[END_POS_W-1:0];
  assign inc_sat  = (inc_wide > EndPosMax) ? '1 : inc_wide[END_POS_W-1:0];

  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      res_o[i] = '0;
    end
    cnt_o = 2'd0;
    st_o  = st_i;

    if (st_i.inside_quote) begin
      if (st_i.escape_pending) begin
        if ((ch_i != cfg_i.quote_char) && (ch_i != cfg_i.escape_char)) begin
          res_o[cnt_o] = mk_text(cfg_i.escape_char);
          cnt_o        = cnt_o + 2'd1;
        end
        res_o[cnt_o]      = mk_text(ch_i);
        cnt_o             = cnt_o + 2'd1;
        st_o.text_emitted   = 1'b1;
        st_o.escape_pending = 1'b0;
      end else if (ch_i == cfg_i.quote_char) begin
        st_o.inside_quote = 1'b0;
      end else if (ch_i == cfg_i.escape_char) begin
        st_o.escape_pending = 1'b1;
      end else if ((ch_i != sp2) && (ch_i != sp3)) begin
        res_o[cnt_o]      = mk_text(ch_i);
        cnt_o             = cnt_o + 2'd1;
        st_o.text_emitted = 1'b1;
      end
    end else if (is_delim) begin
      res_o[cnt_o] = mk_end(REASON_DELIM, pos_sat);
      cnt_o        = cnt_o + 2'd1;
      st_o         = '0;
    end else if (is_space) begin
      st_o.pending_space = 1'b1;
    end else begin
      if (st_i.pending_space && st_i.text_emitted) begin
        res_o[cnt_o] = mk_text(SPACE_CHAR);
        cnt_o        = cnt_o + 2'd1;
      end
      st_o.pending_space = 1'b0;
      if (cfg_i.value_mode && (ch_i == cfg_i.quote_char)) begin
        st_o.inside_quote = 1'b1;
      end else begin
        res_o[cnt_o]      = mk_text(ch_i);
        cnt_o             = cnt_o + 2'd1;
        st_o.text_emitted = 1'b1;
      end
    end

    if (last_i) begin
      res_o[cnt_o] = mk_end(st_o.inside_quote ? REASON_END_QUOTE : REASON_END, inc_sat);
      cnt_o        = cnt_o + 2'd1;
      st_o         = '0;
      pos_o        = '0;
    end else begin
      pos_o = pos_inc;
    end

    if (cnt_o != 2'd0) begin
      res_o[cnt_o - 2'd1].last = 1'b1;
    end
  end

endmodule

// ===== rtl/header_value_tokenizer.sv =====
// Top level of the header value tokenizer: input register, sequencer, output register.
//
// Usage:
//   Slave stream s_axis carries one buffer byte per beat in tdata[7:0]; tlast
//   marks the last byte of a buffer. Master stream m_axis carries one result
//   per beat: tuser is 0 for a token text byte and 1 for an end of token;
//   tdata holds the byte, the end reason and the end position; tlast marks
//   the final result caused by one input byte.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//   the block is idle; a write takes effect at the next clock edge.
//   A byte is accepted into the input register, and its results then pass to
//   the output register one by one. Throughput: one byte per cycle while no
//   byte causes more than one result and m_axis is not stalled; a byte with
//   k results (k is at most three) holds the input register until the last
//   is loaded. Reset empties both registers, clears the token state and the
//   byte position, and loads the register defaults. When the receiver stalls,
//   the output beat holds, the input register fills and s_axis_tready drops.
module header_value_tokenizer #(
  parameter int unsigned POS_BITS = hvt_pkg::POS_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // in_char
  input  logic                               s_axis_tlast,  // in_last
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [hvt_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,  // out_char, end_reason, end_pos
  output logic                               m_axis_tuser,  // out_kind
  output logic                               m_axis_tlast,  // out_last
  input  logic                               cfg_we_i,
  input  logic [hvt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hvt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import hvt_pkg::*;

  cfg_t                cfg;
  result_t             res [MAX_RES];
  logic [1:0]          res_cnt;
  tok_state_t          st_q, st_d, st_next;
  logic [POS_BITS-1:0] pos_q, pos_d, pos_next;

  logic                in_valid_q, in_valid_d;
  logic [7:0]          in_char_q;
  logic                in_last_q;
  logic [1:0]          idx_q, idx_d;
  logic                out_valid_q, out_valid_d;
  result_t             out_q;

  logic                s_accept, load_ok, load, consume;

  hvt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  hvt_classify #(
    .POS_BITS (POS_BITS)
  ) u_classify (
    .cfg_i  (cfg),
    .st_i   (st_q),
    .pos_i  (pos_q),
    .ch_i   (in_char_q),
    .last_i (in_last_q),
    .res_o  (res),
    .cnt_o  (res_cnt),
    .st_o   (st_next),
    .pos_o  (pos_next)
  );

  assign load_ok  = !out_valid_q || m_axis_tready;
  assign load     = in_valid_q && (res_cnt != 2'd0) && load_ok;
  assign consume  = in_valid_q &&
                    ((res_cnt == 2'd0) || (load && (idx_q == res_cnt - 2'd1)));
  assign s_axis_tready = !in_valid_q || consume;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d  = s_accept ? 1'b1 : (consume ? 1'b0 : in_valid_q);
    idx_d       = consume ? 2'd0 : (load ? idx_q + 2'd1 : idx_q);
    out_valid_d = load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);
    st_d        = consume ? st_next : st_q;
    pos_d       = consume ? pos_next : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
      st_q        <= '0;
      pos_q       <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      st_q        <= st_d;
      pos_q       <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (load) begin
      out_q <= res[idx_q];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {6'b0, out_q.pos, out_q.reason, out_q.ch};

endmodule

// ===== rtl/hvt_checker.sv =====
// Port-level checks of the header value tokenizer and their binding.
module hvt_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [hvt_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  input logic                            m_axis_tuser,
  input logic                            m_axis_tlast
);
  import hvt_pkg::*;

  a_text_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_TEXT)) |-> (m_axis_tdata[25:8] == '0))
    else $error("text beat carries reason or position");

  a_end_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_END)) |->
      ((m_axis_tdata[7:0] == '0) && (m_axis_tdata[9:8] != 2'd3)))
    else $error("end beat carries a byte or a bad reason");

  a_quote_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KIND_END) &&
     ((m_axis_tdata[9:8] == REASON_END) || (m_axis_tdata[9:8] == REASON_END_QUOTE)))
      |-> m_axis_tlast)
    else $error("buffer end beat not marked last");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("stalled output beat changed");

endmodule

bind header_value_tokenizer hvt_checker u_hvt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
